### rtl/assert_macros.svh
// assertion helpers used by the checker file
// both sample on the rising edge of clk and are off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tgcr_pkg.sv
// ----------------------------------------------------------------------------
// tgcr_pkg
// Types, constants and the 5x7 font for the text glyph column renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tgcr_pkg;

    // character cell geometry
    localparam int unsigned CELL_W    = 6;
    localparam logic [2:0]  LAST_COL  = 3'd5;
    localparam int unsigned FONT_SIZE = 210;

    // font indexes of the special glyphs
    localparam logic [5:0] IDX_SPACE = 6'd36;
    localparam logic [5:0] IDX_COLON = 6'd37;
    localparam logic [5:0] IDX_MINUS = 6'd38;
    localparam logic [5:0] IDX_DOT   = 6'd39;
    localparam logic [5:0] IDX_QUEST = 6'd40;
    localparam logic [5:0] IDX_GT    = 6'd41;

    typedef logic [7:0] font_rom_t [0:FONT_SIZE-1];

    // one column request on its way to the output register
    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] dirty;
        logic       last;
    } col_req_t;

    // glyph columns, five per glyph, left to right
    localparam font_rom_t FONT_ROM = '{
        8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
        8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
        8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
        8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,  8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,
        8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
        8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A,  8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
        8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,  8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,
        8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,  8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,  8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
        8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,  8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
        8'h46, 8'h49, 8'h49, 8'h49, 8'h31,  8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
        8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,  8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
        8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,  8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
        8'h07, 8'h08, 8'h70, 8'h08, 8'h07,  8'h61, 8'h51, 8'h49, 8'h45, 8'h43,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  8'h00, 8'h36, 8'h36, 8'h00, 8'h00,
        8'h08, 8'h08, 8'h08, 8'h08, 8'h08,  8'h00, 8'h60, 8'h60, 8'h00, 8'h00,
        8'h02, 8'h01, 8'h51, 8'h09, 8'h06,  8'h14, 8'h14, 8'h3E, 8'h14, 8'h14
    };

    // ascii code to glyph index, anything undrawable maps to the question mark
    function automatic logic [5:0] font_index(input logic [7:0] code);
        logic [7:0] idx;
        begin
            idx = {2'b00, IDX_QUEST};
            if (code >= 8'h30 && code <= 8'h39)
            begin
                idx = code - 8'h30;
            end
            else if (code >= 8'h41 && code <= 8'h5A)
            begin
                idx = code - 8'h37;
            end
            else if (code == 8'h20)
            begin
                idx = {2'b00, IDX_SPACE};
            end
            else if (code == 8'h3A)
            begin
                idx = {2'b00, IDX_COLON};
            end
            else if (code == 8'h2D)
            begin
                idx = {2'b00, IDX_MINUS};
            end
            else if (code == 8'h2E)
            begin
                idx = {2'b00, IDX_DOT};
            end
            else if (code == 8'h3E)
            begin
                idx = {2'b00, IDX_GT};
            end
            font_index = idx[5:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/text_glyph_column_renderer_unit.sv
// ----------------------------------------------------------------------------
// text_glyph_column_renderer_unit
// 5x7 character generator: turns each drawn character request into six
// framebuffer column writes and tracks the cursor and dirty pages.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | first_of_string, start_column, page,
//          |                      | char_code
//  out     | out_valid / out_ready| page_out, column, column_bits,
//          |                      | dirty_pages, last
//
//  a drawn character issues one font rom read per cycle, for each of its six
//  columns, unless a stall holds the rom stage; the next request is taken in
//  the cycle its last column is issued. a character that draws nothing only
//  updates the cursor. columns pass the sequencer, the rom read and output reg.
//  reset clears cursor, dirty mask and all valid flags.
//  a stall on out holds the output register, then the rom stage, then in.
`default_nettype none

module text_glyph_column_renderer_unit #(
    parameter int unsigned DISPLAY_WIDTH = 128,
    parameter int unsigned NUM_PAGES     = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       first_of_string,
    input  wire logic [7:0] start_column,
    input  wire logic [7:0] page,
    input  wire logic [7:0] char_code,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      page_out,
    output logic [6:0]      column,
    output logic [7:0]      column_bits,
    output logic [7:0]      dirty_pages,
    output logic            last
);
    import tgcr_pkg::*;

    localparam logic [7:0] LIMIT     = 8'(DISPLAY_WIDTH - CELL_W);
    localparam logic [8:0] PAGE_LIM  = 9'(NUM_PAGES);
    localparam logic [7:0] CELL_STEP = 8'(CELL_W);

    // cursor and dirty state
    logic [7:0] cursor_reg, cursor_next;
    logic [7:0] dirty_reg, dirty_next;

    // character being drawn
    logic       job_active_reg, job_active_next;
    logic [2:0] job_col_reg, job_col_next;
    logic [2:0] job_page_reg;
    logic [7:0] job_base_reg;
    logic [5:0] job_idx_reg;
    logic [7:0] job_dirty_reg;

    // rom read stage
    logic       rd_valid_reg, rd_valid_next;
    col_req_t   rd_req_reg;
    logic [7:0] rom_q_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    col_req_t   out_req_reg;
    logic [7:0] out_bits_reg;

    logic       out_move, rd_move, issue, job_done, accept;
    logic       in_range, page_ok, draw;
    logic [7:0] cur_sel;
    logic [7:0] rom_addr;
    logic [7:0] issue_col;
    col_req_t   issue_req;

    // pipeline flow
    always_comb
    begin
        out_move = !out_valid_reg || out_ready;
        rd_move  = rd_valid_reg && out_move;
        issue    = job_active_reg && (!rd_valid_reg || out_move);
        job_done = issue && (job_col_reg == LAST_COL);
        in_ready = !job_active_reg || job_done;
        accept   = in_valid && in_ready;
    end

    // cursor update and drawing decision
    always_comb
    begin
        cur_sel     = first_of_string ? start_column : cursor_reg;
        in_range    = (cur_sel <= LIMIT);
        page_ok     = ({1'b0, page} < PAGE_LIM);
        draw        = accept && in_range && page_ok;
        cursor_next = cursor_reg;
        if (accept)
        begin
            cursor_next = in_range ? 8'(cur_sel + CELL_STEP) : cur_sel;
        end
        dirty_next = dirty_reg;
        if (draw)
        begin
            dirty_next = dirty_reg | (8'd1 << page[2:0]);
        end
    end

    // column sequencer
    always_comb
    begin
        job_active_next = job_active_reg;
        job_col_next    = job_col_reg;
        if (draw)
        begin
            job_active_next = 1'b1;
            job_col_next    = 3'd0;
        end
        else if (issue)
        begin
            job_active_next = !job_done;
            job_col_next    = 3'(job_col_reg + 3'd1);
        end
    end

    // rom address and column request
    always_comb
    begin
        rom_addr = 8'(({2'b00, job_idx_reg} << 2) + {2'b00, job_idx_reg}
                      + {5'b00000, job_col_reg});
        if (job_col_reg == LAST_COL)
        begin
            rom_addr = 8'd0;
        end
        issue_col        = 8'(job_base_reg + {5'b00000, job_col_reg});
        issue_req.page   = job_page_reg;
        issue_req.column = issue_col[6:0];
        issue_req.dirty  = job_dirty_reg;
        issue_req.last   = (job_col_reg == LAST_COL);
    end

    // stage valid flags
    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (issue)
        begin
            rd_valid_next = 1'b1;
        end
        else if (rd_move)
        begin
            rd_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (rd_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= 8'd0;
            dirty_reg      <= 8'd0;
            job_active_reg <= 1'b0;
            job_col_reg    <= 3'd0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            dirty_reg      <= dirty_next;
            job_active_reg <= job_active_next;
            job_col_reg    <= job_col_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // character payload
    always_ff @(posedge clk)
    begin
        if (draw)
        begin
            job_page_reg  <= page[2:0];
            job_base_reg  <= cur_sel;
            job_idx_reg   <= font_index(char_code);
            job_dirty_reg <= dirty_next;
        end
    end

    // font rom, registered read
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rom_q_reg  <= FONT_ROM[rom_addr];
            rd_req_reg <= issue_req;
        end
    end

    // output register, blank spacing column forced to zero
    always_ff @(posedge clk)
    begin
        if (rd_move)
        begin
            out_req_reg  <= rd_req_reg;
            out_bits_reg <= rd_req_reg.last ? 8'h00 : rom_q_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign page_out    = out_req_reg.page;
    assign column      = out_req_reg.column;
    assign column_bits = out_bits_reg;
    assign dirty_pages = out_req_reg.dirty;
    assign last        = out_req_reg.last;

endmodule

`default_nettype wire

### rtl/tgcr_checker.sv
// ----------------------------------------------------------------------------
// tgcr_checker
// Port-level checks on the column write channel of the renderer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tgcr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] page_out,
    input wire logic [6:0] column,
    input wire logic [7:0] column_bits,
    input wire logic [7:0] dirty_pages,
    input wire logic       last
);

    // a stalled column write holds
    `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({page_out, column, column_bits, dirty_pages, last}), "column write changed while stalled")

    // the target page is always marked dirty
    `AST_IMPL(a_dirty_page, out_valid, dirty_pages[page_out], "target page not in dirty mask")

    // spacing column is blank
    `AST_IMPL(a_blank_last, out_valid && last, column_bits == 8'h00, "spacing column not blank")

    // columns of one character are consecutive on the same page
    `AST_NEXT(a_col_step, out_valid && out_ready && !last, !out_valid || (column == 7'($past(column) + 7'd1) && page_out == $past(page_out)), "glyph columns not consecutive")

endmodule

bind text_glyph_column_renderer_unit tgcr_checker u_tgcr_checker (.*);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives character requests into the glyph column renderer and checks every
// column write against a local model of the font, the cursor and the dirty
// mask. A short table of hand-picked requests comes first, then random
// strings with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int DISPLAY_WIDTH = 128;
    localparam int NUM_PAGES     = 8;
    localparam int GLYPH_W       = 6;
    localparam int LAST_START    = DISPLAY_WIDTH - GLYPH_W;
    localparam int STALL_LIMIT   = 1000;
    localparam int LONG_HOLD     = 90;
    localparam int RANDOM_ITEMS  = 145;
    localparam int HOLD_AT_WORDS = 150;
    localparam int PAUSE_AT      = 50;
    localparam int BURST_FROM    = 80;
    localparam int BURST_TO      = 110;

    // ascii codes with a glyph of their own
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    // font slots of the punctuation glyphs
    localparam int SLOT_SPACE = 36;
    localparam int SLOT_COLON = 37;
    localparam int SLOT_MINUS = 38;
    localparam int SLOT_DOT   = 39;
    localparam int SLOT_QUEST = 40;
    localparam int SLOT_GT    = 41;

    // five columns per glyph, leftmost column in the top byte
    localparam logic [39:0] FONT_5X7 [0:41] = '{
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
        40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
        40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543,
        40'h0000000000, 40'h0036360000, 40'h0808080808, 40'h0060600000,
        40'h0201510906, 40'h14143E1414
    };

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] bits;
        logic [7:0] dirty;
        logic       last;
    } col_write_t;

    // one character request; typed rows carry their own expected writes
    typedef struct packed {
        logic        first;
        logic [7:0]  start;
        logic [7:0]  pg;
        logic [7:0]  code;
        logic        typed;
        logic        draws;
        logic [39:0] glyph;
        logic [7:0]  dirty;
    } stim_row_t;

    // directed requests: extremes, every glyph class, past end, bad pages
    localparam stim_row_t PLAN [0:24] = '{
        '{1'b1, 8'd0,   8'd0,   CH_0,     1'b1, 1'b1, 40'h3E5149453E, 8'h01},
        '{1'b0, 8'd0,   8'd0,   CH_9,     1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd7,   CH_A,     1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b1, 8'd122, 8'd7,   CH_Z,     1'b1, 1'b1, 40'h6151494543, 8'h81},
        '{1'b0, 8'd0,   8'd0,   8'h42,    1'b1, 1'b0, 40'h0, 8'h00},
        '{1'b1, 8'd123, 8'd1,   CH_SPACE, 1'b1, 1'b0, 40'h0, 8'h00},
        '{1'b1, 8'd255, 8'd3,   CH_COLON, 1'b1, 1'b0, 40'h0, 8'h00},
        '{1'b1, 8'd10,  8'd8,   CH_MINUS, 1'b1, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd2,   CH_DOT,   1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd255, CH_GT,    1'b1, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd4,   CH_GT,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd5,   CH_SPACE, 1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd6,   CH_COLON, 1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd1,   CH_MINUS, 1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd3,   8'h00,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd3,   8'hFF,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd3,   CH_QUEST, 1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd0,   8'h2F,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd0,   8'h40,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd0,   8'h5B,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd0,   8'h61,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b1, 8'd127, 8'd0,   8'h80,    1'b1, 1'b0, 40'h0, 8'h00},
        '{1'b1, 8'd116, 8'd2,   8'h57,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd2,   8'h58,    1'b0, 1'b0, 40'h0, 8'h00},
        '{1'b0, 8'd0,   8'd2,   8'h59,    1'b1, 1'b0, 40'h0, 8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       first_of_string;
    logic [7:0] start_column;
    logic [7:0] page;
    logic [7:0] char_code;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] page_out;
    logic [6:0] column;
    logic [7:0] column_bits;
    logic [7:0] dirty_pages;
    logic       last;

    // model state and scoreboard
    logic [7:0] cursor_q;
    logic [7:0] dirty_q;
    col_write_t pending_cols [$];
    int         words_seen = 0;
    int         errors = 0;
    int         idle_cycles = 0;
    bit         no_idle = 1'b0;

    text_glyph_column_renderer_unit #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .NUM_PAGES     (NUM_PAGES)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_of_string (first_of_string),
        .start_column    (start_column),
        .page            (page),
        .char_code       (char_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .page_out        (page_out),
        .column          (column),
        .column_bits     (column_bits),
        .dirty_pages     (dirty_pages),
        .last            (last)
    );

    always #10 clk = ~clk;

    // ascii code to glyph columns
    function automatic logic [39:0] glyph_for(input logic [7:0] code);
        int slot;
        if (code >= CH_0 && code <= CH_9)
            slot = int'(code - CH_0);
        else if (code >= CH_A && code <= CH_Z)
            slot = 10 + int'(code - CH_A);
        else if (code == CH_SPACE)
            slot = SLOT_SPACE;
        else if (code == CH_COLON)
            slot = SLOT_COLON;
        else if (code == CH_MINUS)
            slot = SLOT_MINUS;
        else if (code == CH_DOT)
            slot = SLOT_DOT;
        else if (code == CH_GT)
            slot = SLOT_GT;
        else
            slot = SLOT_QUEST;
        return FONT_5X7[slot];
    endfunction

    // mostly drawable characters, the rest any code
    function automatic logic [7:0] pick_code();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            sel = $urandom_range(0, 41);
            if (sel < 10)
                return 8'(int'(CH_0) + sel);
            if (sel < 36)
                return 8'(int'(CH_A) + sel - 10);
            case (sel)
                SLOT_SPACE: return CH_SPACE;
                SLOT_COLON: return CH_COLON;
                SLOT_MINUS: return CH_MINUS;
                SLOT_DOT:   return CH_DOT;
                SLOT_QUEST: return CH_QUEST;
                default:    return CH_GT;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // queue the six column writes of one drawn character
    task automatic push_cell(input logic [2:0] pg, input logic [7:0] col0,
                             input logic [39:0] g, input logic [7:0] d);
        col_write_t w;
        for (int k = 0; k < GLYPH_W; k++)
        begin
            w.page   = pg;
            w.column = 7'(int'(col0) + k);
            w.bits   = (k < GLYPH_W - 1) ? g[39 - 8 * k -: 8] : 8'h00;
            w.dirty  = d;
            w.last   = (k == GLYPH_W - 1);
            pending_cols.push_back(w);
        end
    endtask

    // cursor and dirty mask update for one request, writes queued if keep
    task automatic render_char(input stim_row_t r, input bit keep);
        if (r.first)
            cursor_q = r.start;
        if (cursor_q > LAST_START)
            return;
        if (r.pg >= NUM_PAGES)
        begin
            cursor_q = 8'(int'(cursor_q) + GLYPH_W);
            return;
        end
        dirty_q[r.pg[2:0]] = 1'b1;
        if (keep)
            push_cell(r.pg[2:0], cursor_q, glyph_for(r.code), dirty_q);
        cursor_q = 8'(int'(cursor_q) + GLYPH_W);
    endtask

    // offer one request after a random gap, predict on acceptance
    task automatic send_row(input stim_row_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        first_of_string <= r.first;
        start_column    <= r.start;
        page            <= r.pg;
        char_code       <= r.code;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        render_char(r, !r.typed);
        if (r.typed && r.draws)
            push_cell(r.pg[2:0], r.start, r.glyph, r.dirty);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // stimulus
    initial
    begin
        stim_row_t r;
        int        len;
        int        sent;
        bit        paused;
        logic [7:0] string_pg;
        in_valid        = 1'b0;
        first_of_string = 1'b0;
        start_column    = 8'h00;
        page            = 8'h00;
        char_code       = 8'h00;
        rst_n           = 1'b0;
        cursor_q        = 8'h00;
        dirty_q         = 8'h00;
        paused          = 1'b0;
        sent            = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < $size(PLAN); i++)
            send_row(PLAN[i]);

        // random strings, mostly well formed
        while (sent < RANDOM_ITEMS)
        begin
            len = $urandom_range(1, 24);
            r.start = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, LAST_START))
                                                 : 8'($urandom_range(0, 255));
            string_pg = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, NUM_PAGES - 1))
                                                   : 8'($urandom_range(0, 255));
            for (int i = 0; i < len && sent < RANDOM_ITEMS; i++)
            begin
                r.first = (i == 0) || ($urandom_range(0, 19) == 0);
                if (r.first && i > 0)
                    r.start = 8'($urandom_range(0, 255));
                r.pg = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                    : string_pg;
                r.code  = pick_code();
                r.typed = 1'b0;
                r.draws = 1'b0;
                r.glyph = 40'h0;
                r.dirty = 8'h00;
                no_idle = (sent >= BURST_FROM) && (sent < BURST_TO);
                // drain everything once before going on
                if (!paused && sent >= PAUSE_AT)
                begin
                    paused = 1'b1;
                    in_valid <= 1'b0;
                    while (pending_cols.size() != 0)
                        @(negedge clk);
                    @(negedge clk);
                end
                send_row(r);
                sent++;
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (pending_cols.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, one long hold-off to back up the input
    initial
    begin
        int gap;
        bit held_long;
        out_ready = 1'b0;
        held_long = 1'b0;
        forever
        begin
            if (!held_long && words_seen >= HOLD_AT_WORDS)
            begin
                held_long = 1'b1;
                gap = LONG_HOLD;
            end
            else
                gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // compare each accepted column write with the oldest expectation
    always @(posedge clk)
    begin
        col_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (pending_cols.size() == 0)
            begin
                $error("unexpected column write: page %0d column %0d", page_out, column);
                errors++;
            end
            else
            begin
                want = pending_cols.pop_front();
                check_field("page_out", want.page, page_out);
                check_field("column", want.column, column);
                check_field("column_bits", want.bits, column_bits);
                check_field("dirty_pages", want.dirty, dirty_pages);
                check_field("last", want.last, last);
            end
        end
    end

    // watchdog on cycles without any accepted request or column write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

`default_nettype wire
